/* sv/bf_pkg.sv */
// Shared types and constants for the Bellman-Ford shortest path block.
// Holds field widths, register indexes, the controller state type and
// the command/status structs between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package bf_pkg;

   // Default sizes for the top-level parameters
   localparam int MAX_VERTICES_DEF = 16;
   localparam int MAX_EDGES_DEF    = 32;
   localparam int WEIGHT_BITS_DEF  = 16;

   // Fixed field widths
   localparam int VERTEX_BITS    = 4;
   localparam int VCOUNT_BITS    = 5;
   localparam int DIST_BITS      = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] REG_VERTEX_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_VERTEX = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNDIRECTED    = 2'd2;

   // Register reset values
   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET     = 5'd7;
   localparam logic [VERTEX_BITS-1:0] SOURCE_RESET     = 4'd0;
   localparam logic                   UNDIRECTED_RESET = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STORE_FWD,
      ST_STORE_REV,
      ST_INIT,
      ST_EDGE_RD,
      ST_DIST_RD,
      ST_CALC,
      ST_UPDATE,
      ST_OUT_RD,
      ST_OUT_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic store_fwd;
      logic store_rev;
      logic init;
      logic edge_rd;
      logic dist_rd;
      logic calc;
      logic update;
      logic out_rd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic undirected;
      logic last_item;
      logic run_passes;
      logic sweep_done;
      logic out_done;
   } status_type;

endpackage

`default_nettype wire

/* sv/bf_ctrl.sv */
// Controller state machine for the Bellman-Ford block.
// Sequences edge storing, relaxation passes and result emission.
// Depends on bf_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module bf_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire bf_pkg::status_type status,
   output bf_pkg::cmd_type         cmd
);

   bf_pkg::state_type state_ff;
   bf_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bf_pkg::ST_IDLE: begin
            if (start) state_in = bf_pkg::ST_STORE_FWD;
         end
         bf_pkg::ST_STORE_FWD: begin
            if (status.undirected) state_in = bf_pkg::ST_STORE_REV;
            else if (status.last_item) state_in = bf_pkg::ST_INIT;
            else state_in = bf_pkg::ST_IDLE;
         end
         bf_pkg::ST_STORE_REV: begin
            if (status.last_item) state_in = bf_pkg::ST_INIT;
            else state_in = bf_pkg::ST_IDLE;
         end
         bf_pkg::ST_INIT: begin
            if (status.run_passes) state_in = bf_pkg::ST_EDGE_RD;
            else state_in = bf_pkg::ST_OUT_RD;
         end
         bf_pkg::ST_EDGE_RD: state_in = bf_pkg::ST_DIST_RD;
         bf_pkg::ST_DIST_RD: state_in = bf_pkg::ST_CALC;
         bf_pkg::ST_CALC:    state_in = bf_pkg::ST_UPDATE;
         bf_pkg::ST_UPDATE: begin
            if (status.sweep_done) state_in = bf_pkg::ST_OUT_RD;
            else state_in = bf_pkg::ST_EDGE_RD;
         end
         bf_pkg::ST_OUT_RD: state_in = bf_pkg::ST_OUT_EMIT;
         bf_pkg::ST_OUT_EMIT: begin
            if (status.out_done) state_in = bf_pkg::ST_IDLE;
            else state_in = bf_pkg::ST_OUT_RD;
         end
         default: state_in = bf_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         bf_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         bf_pkg::ST_STORE_FWD: cmd.store_fwd = 1'b1;
         bf_pkg::ST_STORE_REV: cmd.store_rev = 1'b1;
         bf_pkg::ST_INIT:      cmd.init      = 1'b1;
         bf_pkg::ST_EDGE_RD:   cmd.edge_rd   = 1'b1;
         bf_pkg::ST_DIST_RD:   cmd.dist_rd   = 1'b1;
         bf_pkg::ST_CALC:      cmd.calc      = 1'b1;
         bf_pkg::ST_UPDATE:    cmd.update    = 1'b1;
         bf_pkg::ST_OUT_RD:    cmd.out_rd    = 1'b1;
         bf_pkg::ST_OUT_EMIT:  cmd.emit      = 1'b1;
         default:              busy          = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

/* sv/bf_datapath.sv */
// Datapath for the Bellman-Ford block: config registers, edge memory,
// distance/predecessor memories, relaxation adder and result registers.
// Depends on bf_pkg; driven by commands from bf_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bf_datapath #(
   parameter int MaxVertices = bf_pkg::MAX_VERTICES_DEF,
   parameter int MaxEdges    = bf_pkg::MAX_EDGES_DEF,
   parameter int WeightBits  = bf_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bf_pkg::cmd_type                     cmd,
   output bf_pkg::status_type                       status,
   input  wire logic [bf_pkg::VERTEX_BITS-1:0]      req_edge_from,
   input  wire logic [bf_pkg::VERTEX_BITS-1:0]      req_edge_to,
   input  wire logic signed [WeightBits-1:0]        req_edge_weight,
   input  wire logic                                req_last_edge,
   input  wire logic                                csr_valid,
   input  wire logic [bf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bf_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output logic                                     rsp_valid,
   output logic [bf_pkg::VERTEX_BITS-1:0]           rsp_vertex,
   output logic                                     rsp_reachable,
   output logic signed [bf_pkg::DIST_BITS-1:0]      rsp_distance,
   output logic                                     rsp_has_predecessor,
   output logic [bf_pkg::VERTEX_BITS-1:0]           rsp_predecessor,
   output logic                                     rsp_edges_dropped,
   output logic                                     rsp_last_vertex
);

   localparam int VB    = bf_pkg::VERTEX_BITS;
   localparam int NW    = bf_pkg::VCOUNT_BITS;
   localparam int DB    = bf_pkg::DIST_BITS;
   localparam int VW    = $clog2(MaxVertices);
   localparam int EW    = $clog2(MaxEdges);
   localparam int ECW   = $clog2(MaxEdges + 1);
   localparam int WORDW = 2 * VB + WeightBits;
   localparam int SUMW  = ((WeightBits > DB) ? WeightBits : DB) + 1;

   // Configuration registers
   logic [NW-1:0] vcount_ff;
   logic [VB-1:0] source_ff;
   logic          undirected_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= bf_pkg::VCOUNT_RESET;
         source_ff     <= bf_pkg::SOURCE_RESET;
         undirected_ff <= bf_pkg::UNDIRECTED_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bf_pkg::REG_VERTEX_COUNT:  vcount_ff     <= csr_data[NW-1:0];
            bf_pkg::REG_SOURCE_VERTEX: source_ff     <= csr_data[VB-1:0];
            bf_pkg::REG_UNDIRECTED:    undirected_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Capture the request
   logic [VB-1:0]                req_from_ff;
   logic [VB-1:0]                req_to_ff;
   logic signed [WeightBits-1:0] req_weight_ff;
   logic                         req_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_from_ff   <= req_edge_from;
         req_to_ff     <= req_edge_to;
         req_weight_ff <= req_edge_weight;
         req_last_ff   <= req_last_edge;
      end
   end

   // Clamp vertex count to 1..MaxVertices
   logic [NW-1:0] n_in;
   logic          src_ok;

   always_comb begin
      if (vcount_ff == '0) begin
         n_in = NW'(1);
      end else if (int'(vcount_ff) > MaxVertices) begin
         n_in = NW'(MaxVertices);
      end else begin
         n_in = vcount_ff;
      end
      src_ok = ({1'b0, source_ff} < n_in);
   end

   // Edge list storage: one write per cycle, registered read
   logic [WORDW-1:0] edge_mem [MaxEdges];
   logic [WORDW-1:0] edge_rd_ff;
   logic [ECW-1:0]   edge_count_ff;
   logic [ECW-1:0]   edge_count_in;
   logic             overflow_ff;
   logic             overflow_in;
   logic             store_any;
   logic             room;
   logic [WORDW-1:0] store_word;
   logic [EW-1:0]    e_ff;
   logic [EW-1:0]    e_in;
   logic             e_last;

   assign store_any  = cmd.store_fwd | cmd.store_rev;
   assign room       = (edge_count_ff < ECW'(MaxEdges));
   assign store_word = cmd.store_rev ? {req_to_ff, req_from_ff, req_weight_ff}
                                     : {req_from_ff, req_to_ff, req_weight_ff};

   always_ff @(posedge clock) begin
      if (store_any && room) begin
         edge_mem[edge_count_ff[EW-1:0]] <= store_word;
      end
      if (cmd.edge_rd) begin
         edge_rd_ff <= edge_mem[e_ff];
      end
   end

   logic                         last_emit;

   // Count stored edges, flag drops, clear after the last result
   always_comb begin
      edge_count_in = edge_count_ff;
      overflow_in   = overflow_ff;
      if (store_any) begin
         if (room) edge_count_in = edge_count_ff + ECW'(1);
         else overflow_in = 1'b1;
      end
      if (last_emit) begin
         edge_count_in = '0;
         overflow_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         edge_count_ff <= edge_count_in;
         overflow_ff   <= overflow_in;
      end
   end

   // Fields of the edge under relaxation
   logic [VB-1:0]                er_from;
   logic [VB-1:0]                er_to;
   logic signed [WeightBits-1:0] er_weight;

   assign er_from   = edge_rd_ff[WORDW-1 -: VB];
   assign er_to     = edge_rd_ff[WORDW-VB-1 -: VB];
   assign er_weight = edge_rd_ff[WeightBits-1:0];

   // Pass, edge and output counters
   logic [NW-1:0] n_ff;
   logic [NW-1:0] p_ff;
   logic [NW-1:0] p_in;
   logic [NW-1:0] i_ff;
   logic [NW-1:0] i_in;
   logic          p_last;
   logic          i_last;

   assign e_last    = ((ECW'(e_ff) + ECW'(1)) == edge_count_ff);
   assign p_last    = ((p_ff + NW'(2)) == n_ff);
   assign i_last    = ((i_ff + NW'(1)) == n_ff);
   assign last_emit = cmd.emit && i_last;

   always_comb begin
      e_in = e_ff;
      p_in = p_ff;
      i_in = i_ff;
      if (cmd.init) begin
         e_in = '0;
         p_in = '0;
         i_in = '0;
      end
      if (cmd.update) begin
         if (e_last) begin
            e_in = '0;
            p_in = p_ff + NW'(1);
         end else begin
            e_in = e_ff + EW'(1);
         end
      end
      if (cmd.emit) i_in = i_ff + NW'(1);
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
      p_ff <= p_in;
      i_ff <= i_in;
      if (cmd.init) n_ff <= n_in;
   end

   // Per-vertex reached and predecessor-valid bits
   logic [MaxVertices-1:0] reached_ff;
   logic [MaxVertices-1:0] predv_ff;
   logic [VW-1:0]          u_idx;
   logic [VW-1:0]          v_idx;
   logic [VW-1:0]          i_idx;
   logic [VW-1:0]          src_idx;
   logic                   edge_ok;
   logic                   take;

   assign u_idx   = VW'(er_from);
   assign v_idx   = VW'(er_to);
   assign i_idx   = VW'(i_ff);
   assign src_idx = VW'(source_ff);

   // Distance and predecessor memories
   logic signed [DB-1:0] dist_mem [MaxVertices];
   logic [VB-1:0]        pred_mem [MaxVertices];
   logic signed [DB-1:0] da_ff;
   logic signed [DB-1:0] db_ff;
   logic [VB-1:0]        pa_ff;
   logic [VW-1:0]        addr_a;
   logic signed [DB-1:0] cand_ff;

   assign addr_a  = cmd.out_rd ? i_idx : u_idx;
   assign edge_ok = ({1'b0, er_from} < n_ff) && ({1'b0, er_to} < n_ff)
                    && reached_ff[u_idx];
   assign take    = edge_ok && (!reached_ff[v_idx] || (cand_ff < db_ff));

   always_ff @(posedge clock) begin
      if (cmd.init && src_ok) begin
         dist_mem[src_idx] <= '0;
      end else if (cmd.update && take) begin
         dist_mem[v_idx] <= cand_ff;
         pred_mem[v_idx] <= er_from;
      end
      if (cmd.dist_rd || cmd.out_rd) begin
         da_ff <= dist_mem[addr_a];
         pa_ff <= pred_mem[addr_a];
         db_ff <= dist_mem[v_idx];
      end
   end

   // Start from the source alone, mark each relaxed vertex
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         reached_ff <= src_ok ? (MaxVertices'(1) << src_idx) : '0;
         predv_ff   <= '0;
      end else if (cmd.update && take) begin
         reached_ff[v_idx] <= 1'b1;
         predv_ff[v_idx]   <= 1'b1;
      end
   end

   // Candidate distance, saturated to the distance range
   logic signed [SUMW-1:0] sum;
   logic [SUMW-DB:0]       sum_hi;
   logic signed [DB-1:0]   cand_in;

   always_comb begin
      sum    = SUMW'(da_ff) + SUMW'(er_weight);
      sum_hi = sum[SUMW-1:DB-1];
      if ((&sum_hi) || !(|sum_hi)) begin
         cand_in = sum[DB-1:0];
      end else if (sum[SUMW-1]) begin
         cand_in = {1'b1, {(DB-1){1'b0}}};
      end else begin
         cand_in = {1'b0, {(DB-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) cand_ff <= cand_in;
   end

   // Result registers
   logic                 rsp_valid_ff;
   logic [VB-1:0]        rsp_vertex_ff;
   logic                 rsp_reach_ff;
   logic signed [DB-1:0] rsp_dist_ff;
   logic                 rsp_hp_ff;
   logic [VB-1:0]        rsp_pred_ff;
   logic                 rsp_drop_ff;
   logic                 rsp_last_ff;
   logic                 out_reach;
   logic                 out_hp;

   assign out_reach = reached_ff[i_idx];
   assign out_hp    = out_reach && predv_ff[i_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_vertex_ff <= VB'(i_ff);
         rsp_reach_ff  <= out_reach;
         rsp_dist_ff   <= out_reach ? da_ff : '0;
         rsp_hp_ff     <= out_hp;
         rsp_pred_ff   <= out_hp ? pa_ff : '0;
         rsp_drop_ff   <= overflow_ff;
         rsp_last_ff   <= i_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vertex          = rsp_vertex_ff;
   assign rsp_reachable       = rsp_reach_ff;
   assign rsp_distance        = rsp_dist_ff;
   assign rsp_has_predecessor = rsp_hp_ff;
   assign rsp_predecessor     = rsp_pred_ff;
   assign rsp_edges_dropped   = rsp_drop_ff;
   assign rsp_last_vertex     = rsp_last_ff;

   // Status to the controller
   always_comb begin
      status            = '0;
      status.undirected = undirected_ff;
      status.last_item  = req_last_ff;
      status.run_passes = (n_in > NW'(1)) && (edge_count_ff != '0);
      status.sweep_done = e_last && p_last;
      status.out_done   = i_last;
   end

endmodule

`default_nettype wire

/* sv/bellman_ford_shortest_paths.sv */
// Bellman-Ford single-source shortest paths over a loaded edge list.
// Edge requests are taken on start in idle; busy is high for the store states (reverse
// too when undirected) after the accepting edge. A request marked last adds an init state,
// then (vertex_count-1) passes of edge read, distance read, calc and update per stored edge,
// then a read and an emit state per vertex result; the receiver cannot stall results.
// Reset restores config registers to defaults and clears control, edge count, drop flag.
`timescale 1ns / 1ps
`default_nettype none

module bellman_ford_shortest_paths #(
   parameter int MAX_VERTICES = bf_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = bf_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS  = bf_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [bf_pkg::VERTEX_BITS-1:0]      req_edge_from,
   input  wire logic [bf_pkg::VERTEX_BITS-1:0]      req_edge_to,
   input  wire logic signed [WEIGHT_BITS-1:0]       req_edge_weight,
   input  wire logic                                req_last_edge,
   output logic                                     rsp_valid,
   output logic [bf_pkg::VERTEX_BITS-1:0]           rsp_vertex,
   output logic                                     rsp_reachable,
   output logic signed [bf_pkg::DIST_BITS-1:0]      rsp_distance,
   output logic                                     rsp_has_predecessor,
   output logic [bf_pkg::VERTEX_BITS-1:0]           rsp_predecessor,
   output logic                                     rsp_edges_dropped,
   output logic                                     rsp_last_vertex,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bf_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   bf_pkg::cmd_type    cmd;
   bf_pkg::status_type status;

   // Registers are always writable
   assign csr_ready = 1'b1;

   bf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   bf_datapath #(
      .MaxVertices (MAX_VERTICES),
      .MaxEdges    (MAX_EDGES),
      .WeightBits  (WEIGHT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_edge_from       (req_edge_from),
      .req_edge_to         (req_edge_to),
      .req_edge_weight     (req_edge_weight),
      .req_last_edge       (req_last_edge),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_vertex          (rsp_vertex),
      .rsp_reachable       (rsp_reachable),
      .rsp_distance        (rsp_distance),
      .rsp_has_predecessor (rsp_has_predecessor),
      .rsp_predecessor     (rsp_predecessor),
      .rsp_edges_dropped   (rsp_edges_dropped),
      .rsp_last_vertex     (rsp_last_vertex)
   );

   // A result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding busy cycle");

   // No two result strobes are back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // The final result releases the block
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_vertex) |-> !busy)
      else $error("block still busy at final result");

endmodule

`default_nettype wire
